FILE: rtl/mbe_pkg.sv
// shared types, constants and helpers for the mandelbrot escape-time pixel block
package mbe_pkg;

  // image geometry
  localparam int IMG_WIDTH  = 320;
  localparam int IMG_HEIGHT = 240;

  // field widths
  localparam int COL_W      = 9;
  localparam int ROW_W      = 8;
  localparam int CNT_W      = 11;
  localparam int ZOOM_W     = 29;
  localparam int Q_W        = 32;
  localparam int FRAC_BITS  = 28;
  localparam int GRAY_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // derived datapath widths
  localparam int DCOL_W = COL_W + 1;
  localparam int DROW_W = ROW_W + 1;
  localparam int MAP_W  = DCOL_W + ZOOM_W + 1;
  localparam int ACC_W  = MAP_W + 2;
  localparam int PRD_W  = 2 * Q_W;
  localparam int DIVD_W = CNT_W + GRAY_W;

  // saturation bounds and escape radius squared (4.0 in q4.28)
  localparam logic signed [ACC_W-1:0] Q_MAX_A =
    {{(ACC_W - Q_W + 1){1'b0}}, {(Q_W - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] Q_MIN_A =
    {{(ACC_W - Q_W + 1){1'b1}}, {(Q_W - 1){1'b0}}};
  localparam logic signed [ACC_W-1:0] ESC_MAG = ACC_W'(4) << FRAC_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ITER_LIMIT = 2'd0,
    CFG_ZOOM_STEP  = 2'd1,
    CFG_OFFSET_X   = 2'd2,
    CFG_OFFSET_Y   = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    TOP_IDLE,
    TOP_ITER,
    TOP_DIV,
    TOP_PEND
  } top_state_e;

  typedef enum logic [1:0] {
    IT_IDLE,
    IT_CADD,
    IT_SQ,
    IT_UPD
  } it_state_e;

  typedef struct packed {
    logic [CNT_W-1:0]  iter_limit;
    logic [ZOOM_W-1:0] zoom_step;
    logic [Q_W-1:0]    offset_x;
    logic [Q_W-1:0]    offset_y;
  } cfg_t;

  localparam cfg_t CFG_RST = '{
    iter_limit: 11'd128,
    zoom_step:  29'd2684355,
    offset_x:   32'hF800_0000,
    offset_y:   32'h0000_0000
  };

  // iteration unit result, valid for the single cycle of done
  typedef struct packed {
    logic             done;
    logic             esc;
    logic [CNT_W-1:0] cnt;
  } iter_res_t;

  typedef struct packed {
    logic              esc;
    logic [CNT_W-1:0]  cnt;
    logic [CNT_W-1:0]  rem;
    logic [GRAY_W-1:0] low;
    logic [GRAY_W-1:0] quo;
  } div_pay_t;

  typedef struct packed {
    logic     vld;
    div_pay_t pay;
  } div_stage_t;

  function automatic logic [Q_W-1:0] sat_q(input logic signed [ACC_W-1:0] v);
    logic [Q_W-1:0] r;
    if (v > Q_MAX_A) begin
      r = Q_MAX_A[Q_W-1:0];
    end else if (v < Q_MIN_A) begin
      r = Q_MIN_A[Q_W-1:0];
    end else begin
      r = v[Q_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/mbe_div_cell.sv
// one restoring-division cell: produces one quotient bit and passes the remainder on
module mbe_div_cell import mbe_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CNT_W-1:0] divisor_i,
  input  div_stage_t       stage_i,
  output div_stage_t       stage_o
);

  logic             vld_q;
  div_pay_t         pay_q;
  div_pay_t         pay_d;
  logic [CNT_W:0]   trial;
  logic [CNT_W:0]   diff;
  logic             fits;

  always_comb begin
    trial = {stage_i.pay.rem, stage_i.pay.low[GRAY_W-1]};
    diff  = trial - {1'b0, divisor_i};
    fits  = trial >= {1'b0, divisor_i};
    pay_d     = stage_i.pay;
    pay_d.rem = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    pay_d.low = {stage_i.pay.low[GRAY_W-2:0], 1'b0};
    pay_d.quo = {stage_i.pay.quo[GRAY_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= stage_i.vld;
    end
  end

  // payload only moves with a valid item, so the last cell holds its result
  always_ff @(posedge clk_i) begin
    if (stage_i.vld) begin
      pay_q <= pay_d;
    end
  end

  assign stage_o.vld = vld_q;
  assign stage_o.pay = pay_q;

endmodule

FILE: rtl/mbe_div_chain.sv
// chain of division cells computing floor(count*255/limit)
module mbe_div_chain import mbe_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  iter_res_t        res_i,
  input  logic [CNT_W-1:0] divisor_i,
  output div_stage_t       tail_o
);

  logic [DIVD_W-1:0] dividend;
  div_stage_t        link [GRAY_W+1];

  // count*255 as count*256 - count
  always_comb begin
    dividend         = {res_i.cnt, {GRAY_W{1'b0}}} - DIVD_W'(res_i.cnt);
    link[0].vld      = res_i.done;
    link[0].pay.esc  = res_i.esc;
    link[0].pay.cnt  = res_i.cnt;
    link[0].pay.rem  = dividend[DIVD_W-1:GRAY_W];
    link[0].pay.low  = dividend[GRAY_W-1:0];
    link[0].pay.quo  = '0;
  end

  for (genvar i = 0; i < GRAY_W; i++) begin : g_cell
    mbe_div_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .divisor_i (divisor_i),
      .stage_i   (link[i]),
      .stage_o   (link[i+1])
    );
  end

  assign tail_o = link[GRAY_W];

endmodule

FILE: rtl/mbe_iter.sv
// pixel mapping and shared z = z^2 + c iteration unit
module mbe_iter import mbe_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [COL_W-1:0] column_i,
  input  logic [ROW_W-1:0] row_i,
  input  cfg_t             cfg_i,
  output iter_res_t        res_o
);

  it_state_e state_q, state_d;

  logic signed [MAP_W-1:0] xp_q, xp_d, yp_q, yp_d;
  logic signed [Q_W-1:0]   cre_q, cre_d, cim_q, cim_d;
  logic signed [Q_W-1:0]   re_q, re_d, im_q, im_d;
  logic signed [PRD_W-1:0] rr_q, rr_d, ii_q, ii_d, ri_q, ri_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;

  logic signed [DCOL_W-1:0] dcol;
  logic signed [DROW_W-1:0] drow;
  logic signed [ZOOM_W:0]   zoom_s;
  logic signed [ACC_W-1:0]  sr, si, pr, mag;
  logic signed [Q_W-1:0]    cre_n, cim_n, re_n, im_n;
  logic                     stop;

  // mapping and update arithmetic
  always_comb begin
    dcol   = $signed({1'b0, column_i}) - $signed(DCOL_W'(IMG_WIDTH / 2));
    drow   = $signed({1'b0, row_i}) - $signed(DROW_W'(IMG_HEIGHT / 2));
    zoom_s = $signed({1'b0, cfg_i.zoom_step});
    cre_n  = $signed(sat_q(ACC_W'(xp_q) + ACC_W'($signed(cfg_i.offset_x))));
    cim_n  = $signed(sat_q(ACC_W'(yp_q) + ACC_W'($signed(cfg_i.offset_y))));
    sr     = ACC_W'(rr_q >>> FRAC_BITS);
    si     = ACC_W'(ii_q >>> FRAC_BITS);
    pr     = ACC_W'(ri_q >>> (FRAC_BITS - 1));
    mag    = sr + si;
    re_n   = $signed(sat_q(sr - si + ACC_W'(cre_q)));
    im_n   = $signed(sat_q(pr + ACC_W'(cim_q)));
    // squares of the current z give the magnitude of the previous step
    stop   = (cnt_q >= cfg_i.iter_limit) || ((cnt_q != '0) && (mag >= ESC_MAG));
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      IT_IDLE: if (start_i) state_d = IT_CADD;
      IT_CADD: state_d = IT_SQ;
      IT_SQ:   state_d = IT_UPD;
      IT_UPD:  state_d = stop ? IT_IDLE : IT_SQ;
      default: state_d = IT_IDLE;
    endcase
  end

  // datapath register loads
  always_comb begin
    xp_d  = xp_q;
    yp_d  = yp_q;
    cre_d = cre_q;
    cim_d = cim_q;
    re_d  = re_q;
    im_d  = im_q;
    rr_d  = rr_q;
    ii_d  = ii_q;
    ri_d  = ri_q;
    cnt_d = cnt_q;
    case (state_q)
      IT_IDLE: begin
        xp_d = MAP_W'(dcol) * MAP_W'(zoom_s);
        yp_d = MAP_W'(drow) * MAP_W'(zoom_s);
      end
      IT_CADD: begin
        cre_d = cre_n;
        cim_d = cim_n;
        re_d  = cre_n;
        im_d  = cim_n;
        cnt_d = '0;
      end
      IT_SQ: begin
        rr_d = PRD_W'(re_q) * PRD_W'(re_q);
        ii_d = PRD_W'(im_q) * PRD_W'(im_q);
        ri_d = PRD_W'(re_q) * PRD_W'(im_q);
      end
      IT_UPD: begin
        if (!stop) begin
          re_d  = re_n;
          im_d  = im_n;
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    res_o.done = (state_q == IT_UPD) && stop;
    res_o.esc  = cnt_q < cfg_i.iter_limit;
    res_o.cnt  = cnt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IT_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    xp_q  <= xp_d;
    yp_q  <= yp_d;
    cre_q <= cre_d;
    cim_q <= cim_d;
    re_q  <= re_d;
    im_q  <= im_d;
    rr_q  <= rr_d;
    ii_q  <= ii_d;
    ri_q  <= ri_d;
    cnt_q <= cnt_d;
  end

endmodule

FILE: rtl/mandelbrot_escape_time_pixel.sv
// top level of the mandelbrot escape-time pixel evaluator
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   column_i, row_i
//   out      output     out_valid_o / out_stall_i intensity_o, iterations_o, escaped_o
//   cfg      input      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// one pixel is in work at a time; after its transfer a pixel passes through
// the mapping and offset add, a square and an update step per iteration plus a final
// magnitude check, eight divider cells and the output register, which raises out_valid_o
// in_stall_o is high from the input transfer until the result enters the output register,
// so a new pixel is taken only once the previous result is in the output register
// the output register lets a new pixel start while the previous result waits
// reset loads the default view and a limit of 128; no clearing pass
module mandelbrot_escape_time_pixel import mbe_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // pixel input channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [COL_W-1:0]      column_i,
  input  logic [ROW_W-1:0]      row_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [GRAY_W-1:0]     intensity_o,
  output logic [CNT_W-1:0]      iterations_o,
  output logic                  escaped_o,
  // configuration writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  top_state_e state_q, state_d;

  cfg_t       cfg_q, cfg_d;
  iter_res_t  iter_res;
  div_stage_t tail;

  logic              in_xfer;
  logic              out_free;
  logic              out_load;
  logic              out_valid_q, out_valid_d;
  logic [GRAY_W-1:0] intensity_q;
  logic [CNT_W-1:0]  iterations_q;
  logic              escaped_q;

  // configuration registers; the user writes them only while idle, the block does not enforce it
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ITER_LIMIT: cfg_d.iter_limit = cfg_data_i[CNT_W-1:0];
        CFG_ZOOM_STEP:  cfg_d.zoom_step  = cfg_data_i[ZOOM_W-1:0];
        CFG_OFFSET_X:   cfg_d.offset_x   = cfg_data_i[Q_W-1:0];
        CFG_OFFSET_Y:   cfg_d.offset_y   = cfg_data_i[Q_W-1:0];
        default: ;
      endcase
    end
  end

  // iteration unit: maps the pixel to c and counts escape-time steps
  mbe_iter u_iter (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_xfer),
    .column_i (column_i),
    .row_i    (row_i),
    .cfg_i    (cfg_q),
    .res_o    (iter_res)
  );

  // gray level divider, one quotient bit per cell
  mbe_div_chain u_div_chain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .res_i     (iter_res),
    .divisor_i (cfg_q.iter_limit),
    .tail_o    (tail)
  );

  // output register is free when empty or when its result leaves this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      TOP_IDLE: if (in_xfer) state_d = TOP_ITER;
      TOP_ITER: if (iter_res.done) state_d = TOP_DIV;
      TOP_DIV: begin
        if (tail.vld) begin
          state_d = out_free ? TOP_IDLE : TOP_PEND;
        end
      end
      // divider tail keeps its result until the output register frees up
      TOP_PEND: if (out_free) state_d = TOP_IDLE;
      default:  state_d = TOP_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall_o = (state_q != TOP_IDLE);
    in_xfer    = in_valid_i && (state_q == TOP_IDLE);
    out_load   = out_free && (((state_q == TOP_DIV) && tail.vld) || (state_q == TOP_PEND));
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= TOP_IDLE;
      cfg_q       <= CFG_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload; points that never escaped are drawn black
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      intensity_q  <= tail.pay.esc ? tail.pay.quo : '0;
      iterations_q <= tail.pay.cnt;
      escaped_q    <= tail.pay.esc;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign intensity_o  = intensity_q;
  assign iterations_o = iterations_q;
  assign escaped_o    = escaped_q;

endmodule

FILE: rtl/mbe_checker.sv
// port-level checker for the mandelbrot escape-time pixel block, with its bind
module mbe_checker import mbe_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [GRAY_W-1:0]     intensity_o,
  input logic [CNT_W-1:0]      iterations_o,
  input logic                  escaped_o
);

  // a pixel in work blocks the next transfer
  a_one_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a pixel is in work");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(intensity_o) &&
    $stable(iterations_o) && $stable(escaped_o))
    else $error("stalled result changed");

  // points inside the set are black
  a_dark_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !escaped_o |-> intensity_o == '0)
    else $error("nonzero intensity for a point that did not escape");

  // escape needs at least one step and stays below full scale
  a_escape_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && escaped_o |-> (iterations_o != '0) && (intensity_o != {GRAY_W{1'b1}}))
    else $error("escaped result out of range");

endmodule

bind mandelbrot_escape_time_pixel mbe_checker u_mbe_checker (.*);

FILE: bench/mandelbrot_escape_time_pixel_test.sv
// self-checking bench for the mandelbrot escape-time pixel evaluator
`timescale 1ns / 1ps

module mandelbrot_escape_time_pixel_test;
  import mbe_pkg::*;

  // quiet cycles allowed before the watchdog trips, sized for a 2047-iteration pixel
  localparam int QUIET_LIMIT = 40000;
  localparam int ITEM_GOAL   = 1600;

  typedef struct packed {
    logic [GRAY_W-1:0] gray;
    logic [CNT_W-1:0]  count;
    logic              esc;
  } pixel_res_t;

  // holds its own copy of the view registers and the results still owed
  class escape_ledger;
    logic [CNT_W-1:0]  limit;
    logic [ZOOM_W-1:0] zoom;
    longint            off_re;
    longint            off_im;
    pixel_res_t        due_q[$];
    int                mismatches;
    int                results;
    int                escapes;
    int                held;

    function new();
      limit  = 11'd128;
      zoom   = 29'd2684355;
      off_re = -64'sd134217728;
      off_im = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        CFG_ITER_LIMIT: limit  = d[CNT_W-1:0];
        CFG_ZOOM_STEP:  zoom   = d[ZOOM_W-1:0];
        CFG_OFFSET_X:   off_re = longint'($signed(d));
        CFG_OFFSET_Y:   off_im = longint'($signed(d));
        default: ;
      endcase
    endfunction

    // clamp to the q4.28 range
    function longint clamp_q(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function pixel_res_t escape_time(logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
      longint      c_re, c_im, re, im, sr, si, twice_ri, mag;
      int unsigned cnt;
      pixel_res_t  r;
      c_re = clamp_q((longint'(col) - IMG_WIDTH / 2) * longint'(zoom) + off_re);
      c_im = clamp_q((longint'(row) - IMG_HEIGHT / 2) * longint'(zoom) + off_im);
      re   = c_re;
      im   = c_im;
      mag  = 0;
      cnt  = 0;
      // products are exact in 64 bits, arithmetic shift floors them
      while (cnt < limit && mag < (64'sd1 <<< 30)) begin
        sr       = (re * re) >>> FRAC_BITS;
        si       = (im * im) >>> FRAC_BITS;
        twice_ri = (re * im) >>> (FRAC_BITS - 1);
        re       = clamp_q(sr - si + c_re);
        im       = clamp_q(twice_ri + c_im);
        mag      = ((re * re) >>> FRAC_BITS) + ((im * im) >>> FRAC_BITS);
        cnt++;
      end
      r.esc   = (cnt < limit);
      r.count = cnt[CNT_W-1:0];
      r.gray  = r.esc ? GRAY_W'((cnt * 255) / limit) : '0;
      return r;
    endfunction

    function void note_pixel(logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
      pixel_res_t r;
      r = escape_time(col, row);
      if (r.esc) escapes++;
      else held++;
      due_q.push_back(r);
    endfunction

    function void check_result(logic [GRAY_W-1:0] gray, logic [CNT_W-1:0] cnt, logic esc);
      pixel_res_t want;
      results++;
      if (due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%t: result with no pixel pending: gray %0d count %0d esc %0b",
                   $realtime, gray, cnt, esc);
        return;
      end
      want = due_q.pop_front();
      if (gray !== want.gray || cnt !== want.count || esc !== want.esc) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%t: mismatch exp gray %0d count %0d esc %0b, got gray %0d count %0d esc %0b",
                   $realtime, want.gray, want.count, want.esc, gray, cnt, esc);
      end
    endfunction

    function int pending();
      return due_q.size();
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [COL_W-1:0]      column_i = '0;
  logic [ROW_W-1:0]      row_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [GRAY_W-1:0]     intensity_o;
  logic [CNT_W-1:0]      iterations_o;
  logic                  escaped_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  escape_ledger sb;
  int           sent;
  int           views;
  int           quiet_cycles;

  mandelbrot_escape_time_pixel u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .column_i     (column_i),
    .row_i        (row_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .intensity_o  (intensity_o),
    .iterations_o (iterations_o),
    .escaped_o    (escaped_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // monitor: sees every transfer and register write at the edge it happens,
  // sampling pre-edge values, and runs the watchdog on quiet cycles
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.write_reg(cfg_idx_e'(cfg_idx_i), cfg_data_i);
      if (in_valid_i && !in_stall_o) sb.note_pixel(column_i, row_i);
      if (out_valid_o && !out_stall_i) sb.check_result(intensity_o, iterations_o, escaped_o);
      if (cfg_we_i || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results owed",
                 QUIET_LIMIT, sb.pending());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // result-side back-pressure: short stalls mostly, some long ones, and
  // long stretches with none at all
  initial begin
    int r;
    int run_len;
    int hold_len;
    @(posedge rst_ni);
    forever begin
      r = $urandom_range(0, 99);
      if (r < 70) run_len = $urandom_range(1, 6);
      else if (r < 90) run_len = $urandom_range(7, 40);
      else run_len = $urandom_range(100, 400);
      r = $urandom_range(0, 99);
      if (r < 75) hold_len = $urandom_range(1, 3);
      else if (r < 95) hold_len = $urandom_range(4, 15);
      else hold_len = $urandom_range(30, 120);
      out_stall_i <= 1'b0;
      repeat (run_len) @(posedge clk_i);
      out_stall_i <= 1'b1;
      repeat (hold_len) @(posedge clk_i);
    end
  end

  // sender idle length: mostly back to back, a few long pauses
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(50, 300);
  endfunction

  // all tasks below start and end on a rising edge
  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] d);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
  endtask

  // called only with the block idle and nothing owed
  task automatic set_view(logic [CNT_W-1:0] lim, logic [ZOOM_W-1:0] zoom,
                          logic [31:0] ox, logic [31:0] oy);
    write_reg(CFG_ITER_LIMIT, CFG_DATA_W'(lim));
    write_reg(CFG_ZOOM_STEP, CFG_DATA_W'(zoom));
    write_reg(CFG_OFFSET_X, ox);
    write_reg(CFG_OFFSET_Y, oy);
    cfg_we_i <= 1'b0;
    views++;
  endtask

  task automatic drain();
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic send_pixel(logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
    in_valid_i <= 1'b1;
    column_i   <= col;
    row_i      <= row;
    do @(posedge clk_i); while (in_stall_o);
    sent++;
  endtask

  // idle after a transfer; now and then hold off until every result is back
  task automatic pace(bit last);
    int  gap;
    bit  hold;
    gap  = idle_len();
    hold = ($urandom_range(0, 39) == 0);
    if (last || hold || gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      if (last || hold) drain();
    end
  endtask

  // pixels mostly inside the image, the rest anywhere the fields allow;
  // both corners of the field ranges lead each view
  task automatic run_view(int n);
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    for (int i = 0; i < n; i++) begin
      if (i == 0) begin
        col = '0;
        row = '0;
      end else if (i == 1) begin
        col = '1;
        row = '1;
      end else begin
        col = ($urandom_range(0, 99) < 85) ? COL_W'($urandom_range(0, IMG_WIDTH - 1))
                                           : COL_W'($urandom);
        row = ($urandom_range(0, 99) < 85) ? ROW_W'($urandom_range(0, IMG_HEIGHT - 1))
                                           : ROW_W'($urandom);
      end
      send_pixel(col, row);
      pace(i == n - 1);
    end
  endtask

  initial begin
    logic [COL_W-1:0] dir_col[10] = '{9'd319, 9'd0, 9'd511, 9'd160, 9'd320,
                                      9'd159, 9'd1, 9'd256, 9'd100, 9'd255};
    logic [ROW_W-1:0] dir_row[10] = '{8'd239, 8'd255, 8'd0, 8'd120, 8'd240,
                                      8'd119, 8'd2, 8'd128, 8'd60, 8'd127};
    logic [CNT_W-1:0]  lim;
    logic [ZOOM_W-1:0] zoom;
    logic [31:0]       ox;
    logic [31:0]       oy;
    int                n;

    sb    = new();
    sent  = 0;
    views = 1;
    quiet_cycles = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset view: the last image pixel, field extremes, the image centre, first pixels off the image
    for (int i = 0; i < 10; i++) begin
      send_pixel(dir_col[i], dir_row[i]);
      pace(i == 9);
    end
    run_view(300);

    // zero limit: nothing iterates
    set_view('0, ZOOM_W'($urandom), $urandom, $urandom);
    run_view(30);
    // limit of one: pixels escaping on the only step count as held
    set_view(11'd1, 29'd2684355, 32'hF800_0000, 32'h0);
    run_view(60);
    // largest limit at c = 0 with zero zoom: full run every pixel
    set_view(11'd2047, '0, 32'h0, 32'h0);
    run_view(4);
    // small zoom near the set boundary: long escape times
    set_view(11'd1024, 29'd268, 32'hF400_0000, 32'h0199_999A);
    run_view(12);
    // widest zoom with offsets at both extremes: c and z saturate
    set_view(11'd64, '1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    run_view(60);
    set_view(11'd64, '1, 32'h8000_0000, 32'h8000_0000);
    run_view(60);
    // one unit per pixel: almost everything escapes at once
    set_view(11'd1024, 29'd268435456, 32'hF800_0000, 32'h0);
    run_view(40);

    // random views, kept around the set most of the time
    while (sent < ITEM_GOAL) begin
      lim  = ($urandom_range(0, 7) == 0) ? CNT_W'($urandom_range(161, 700))
                                         : CNT_W'($urandom_range(1, 160));
      zoom = ZOOM_W'($urandom & ((32'd1 << $urandom_range(9, ZOOM_W)) - 1));
      if ($urandom_range(0, 5) == 0) begin
        ox = $urandom;
        oy = $urandom;
      end else begin
        ox = 32'($urandom_range(0, 805306368)) - 32'd536870912;
        oy = 32'($urandom_range(0, 536870912)) - 32'd268435456;
      end
      n = (lim > 160) ? 25 : 120;
      set_view(lim, zoom, ox, oy);
      run_view(n);
    end

    drain();
    repeat (40) @(posedge clk_i);
    $display("covered %0d pixels over %0d views: %0d escaped, %0d held at the limit",
             sent, views, sb.escapes, sb.held);
    $display("limits 0 to 2047, zoom 0 to full scale, offsets at both rails; %0d mismatches",
             sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/mbe_pkg.sv
rtl/mbe_div_cell.sv
rtl/mbe_div_chain.sv
rtl/mbe_iter.sv
rtl/mandelbrot_escape_time_pixel.sv
rtl/mbe_checker.sv
bench/mandelbrot_escape_time_pixel_test.sv
